// ----- design/mexp_pkg.sv -----
`default_nettype none

package mexp_pkg;

    // word and counter sizes
    localparam int WORD_WIDTH = 32;
    localparam int CNT_W      = $clog2(WORD_WIDTH + 1);
    localparam int PC_W       = 4;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(1);

    // register reset values
    localparam logic [WORD_WIDTH-1:0] EXPONENT_RESET = WORD_WIDTH'(64'd65537);
    localparam logic [WORD_WIDTH-1:0] MODULUS_RESET  = WORD_WIDTH'(64'd4294967291);

    // datapath operations
    typedef logic [3:0] op_t;
    localparam op_t OP_NOP     = 4'd0;
    localparam op_t OP_LOAD    = 4'd1;
    localparam op_t OP_MUL     = 4'd2;
    localparam op_t OP_SETA    = 4'd3;
    localparam op_t OP_SQ_INIT = 4'd4;
    localparam op_t OP_ML_INIT = 4'd5;
    localparam op_t OP_TAKE_P  = 4'd6;
    localparam op_t OP_NEXT    = 4'd7;
    localparam op_t OP_OUT     = 4'd8;
    localparam op_t OP_ZERO    = 4'd9;

    // jump conditions
    typedef logic [2:0] jc_t;
    localparam jc_t JC_NONE     = 3'd0;
    localparam jc_t JC_ALWAYS   = 3'd1;
    localparam jc_t JC_NO_INPUT = 3'd2;
    localparam jc_t JC_MUL_MORE = 3'd3;
    localparam jc_t JC_EBIT0    = 3'd4;
    localparam jc_t JC_E_MORE   = 3'd5;
    localparam jc_t JC_M_SMALL  = 3'd6;
    localparam jc_t JC_OUT_BUSY = 3'd7;

    // one microprogram word
    typedef struct packed {
        logic            accept;
        op_t             op;
        jc_t             jc;
        logic [PC_W-1:0] target;
    } cw_t;

    // sequencer to datapath
    typedef struct packed {
        op_t op;
    } ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic mul_last;
        logic ebit;
        logic e_last;
        logic m_small;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

// ----- design/mexp_seq.sv -----
`default_nettype none

module mexp_seq import mexp_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t st,
    output ctrl_t        ctrl
);

    // microprogram
    function automatic cw_t rom_word(input logic [PC_W-1:0] pc);
        cw_t w;
        w = '{accept: 1'b0, op: OP_NOP, jc: JC_ALWAYS, target: PC_W'(0)};
        unique case (pc)
            // wait for a transfer and capture the message
            PC_W'(0):  w = '{accept: 1'b1, op: OP_LOAD, jc: JC_NO_INPUT, target: PC_W'(0)};
            PC_W'(1):  w = '{accept: 1'b0, op: OP_NOP, jc: JC_M_SMALL, target: PC_W'(13)};
            // base mod m as 1 * message
            PC_W'(2):  w = '{accept: 1'b0, op: OP_MUL, jc: JC_MUL_MORE, target: PC_W'(2)};
            PC_W'(3):  w = '{accept: 1'b0, op: OP_SETA, jc: JC_NONE, target: PC_W'(0)};
            // square
            PC_W'(4):  w = '{accept: 1'b0, op: OP_SQ_INIT, jc: JC_NONE, target: PC_W'(0)};
            PC_W'(5):  w = '{accept: 1'b0, op: OP_MUL, jc: JC_MUL_MORE, target: PC_W'(5)};
            PC_W'(6):  w = '{accept: 1'b0, op: OP_TAKE_P, jc: JC_EBIT0, target: PC_W'(10)};
            // multiply by base
            PC_W'(7):  w = '{accept: 1'b0, op: OP_ML_INIT, jc: JC_NONE, target: PC_W'(0)};
            PC_W'(8):  w = '{accept: 1'b0, op: OP_MUL, jc: JC_MUL_MORE, target: PC_W'(8)};
            PC_W'(9):  w = '{accept: 1'b0, op: OP_TAKE_P, jc: JC_NONE, target: PC_W'(0)};
            // next exponent bit
            PC_W'(10): w = '{accept: 1'b0, op: OP_NEXT, jc: JC_E_MORE, target: PC_W'(4)};
            // hand result to the output register
            PC_W'(11): w = '{accept: 1'b0, op: OP_OUT, jc: JC_OUT_BUSY, target: PC_W'(11)};
            PC_W'(12): w = '{accept: 1'b0, op: OP_NOP, jc: JC_ALWAYS, target: PC_W'(0)};
            // modulus below two
            PC_W'(13): w = '{accept: 1'b0, op: OP_ZERO, jc: JC_ALWAYS, target: PC_W'(11)};
            default:   w = '{accept: 1'b0, op: OP_NOP, jc: JC_ALWAYS, target: PC_W'(0)};
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    cw_t             cw;
    logic            taken;

    assign cw = rom_word(pc_reg);

    // jump condition
    always_comb begin
        unique case (cw.jc)
            JC_NONE:     taken = 1'b0;
            JC_ALWAYS:   taken = 1'b1;
            JC_NO_INPUT: taken = !s_valid;
            JC_MUL_MORE: taken = !st.mul_last;
            JC_EBIT0:    taken = !st.ebit;
            JC_E_MORE:   taken = !st.e_last;
            JC_M_SMALL:  taken = st.m_small;
            JC_OUT_BUSY: taken = st.out_busy;
            default:     taken = 1'b0;
        endcase
    end

    assign pc_next = taken ? cw.target : pc_reg + PC_W'(1);

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else begin
            pc_reg <= pc_next;
        end
    end

    // load and output only take effect when their handshake allows
    always_comb begin
        ctrl.op = cw.op;
        if ((cw.op == OP_LOAD && !s_valid) || (cw.op == OP_OUT && st.out_busy)) begin
            ctrl.op = OP_NOP;
        end
    end

    assign s_ready = cw.accept;

    // a transfer always leaves the idle step
    a_accept_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (pc_reg == PC_W'(1)))
        else $error("sequencer stayed idle after input transfer");

    // the multiply loop only exits on its last bit
    a_mul_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.op == OP_MUL && !st.mul_last) |=> (pc_reg == $past(pc_reg)))
        else $error("multiply loop left early");

    // a result is only issued when the output register is free
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_OUT) |-> !st.out_busy)
        else $error("result issued over a pending result");

endmodule

`default_nettype wire

// ----- design/mexp_dp.sv -----
`default_nettype none

module mexp_dp import mexp_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ctrl_t                 ctrl,
    output status_t                    st,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [WORD_WIDTH-1:0] cfg_wdata,
    input  wire logic [WORD_WIDTH-1:0] s_message,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [WORD_WIDTH-1:0]      m_result
);

    logic [WORD_WIDTH-1:0] exp_cfg_reg;
    logic [WORD_WIDTH-1:0] mod_cfg_reg;
    logic [WORD_WIDTH-1:0] acc_reg;
    logic [WORD_WIDTH-1:0] a_reg;
    logic [WORD_WIDTH-1:0] x_reg;
    logic [WORD_WIDTH-1:0] b_reg;
    logic [WORD_WIDTH-1:0] p_reg;
    logic [WORD_WIDTH-1:0] e_reg;
    logic [CNT_W-1:0]      mcnt_reg;
    logic [CNT_W-1:0]      ecnt_reg;
    logic                  m_valid_reg;
    logic [WORD_WIDTH-1:0] m_result_reg;

    logic [WORD_WIDTH:0]   mod_ext;
    logic [WORD_WIDTH:0]   dbl;
    logic [WORD_WIDTH:0]   dbl_red;
    logic [WORD_WIDTH:0]   sum;
    logic [WORD_WIDTH:0]   sum_red;
    logic [WORD_WIDTH-1:0] p_next;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_cfg_reg <= EXPONENT_RESET;
            mod_cfg_reg <= MODULUS_RESET;
        end else if (cfg_we) begin
            if (cfg_index == REG_EXPONENT) begin
                exp_cfg_reg <= cfg_wdata;
            end else if (cfg_index == REG_MODULUS) begin
                mod_cfg_reg <= cfg_wdata;
            end
        end
    end

    // one double-and-add step of the modular product
    always_comb begin
        mod_ext = {1'b0, mod_cfg_reg};
        dbl     = {p_reg, 1'b0};
        dbl_red = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
        sum     = dbl_red + {1'b0, x_reg};
        sum_red = (sum >= mod_ext) ? sum - mod_ext : sum;
        p_next  = b_reg[WORD_WIDTH-1] ? sum_red[WORD_WIDTH-1:0] : dbl_red[WORD_WIDTH-1:0];
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_LOAD: begin
                x_reg    <= WORD_WIDTH'(1);
                b_reg    <= s_message;
                p_reg    <= '0;
                mcnt_reg <= CNT_W'(WORD_WIDTH);
                e_reg    <= exp_cfg_reg;
                ecnt_reg <= CNT_W'(WORD_WIDTH);
            end
            OP_MUL: begin
                p_reg    <= p_next;
                b_reg    <= {b_reg[WORD_WIDTH-2:0], 1'b0};
                mcnt_reg <= mcnt_reg - CNT_W'(1);
            end
            OP_SETA: begin
                a_reg   <= p_reg;
                acc_reg <= WORD_WIDTH'(1);
            end
            OP_SQ_INIT: begin
                x_reg    <= acc_reg;
                b_reg    <= acc_reg;
                p_reg    <= '0;
                mcnt_reg <= CNT_W'(WORD_WIDTH);
            end
            OP_ML_INIT: begin
                x_reg    <= a_reg;
                b_reg    <= acc_reg;
                p_reg    <= '0;
                mcnt_reg <= CNT_W'(WORD_WIDTH);
            end
            OP_TAKE_P: begin
                acc_reg <= p_reg;
            end
            OP_NEXT: begin
                e_reg    <= {e_reg[WORD_WIDTH-2:0], 1'b0};
                ecnt_reg <= ecnt_reg - CNT_W'(1);
            end
            OP_ZERO: begin
                acc_reg <= '0;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.op == OP_OUT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.op == OP_OUT) begin
            m_result_reg <= acc_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    // status to the sequencer
    assign st.mul_last = (mcnt_reg == CNT_W'(1));
    assign st.ebit     = e_reg[WORD_WIDTH-1];
    assign st.e_last   = (ecnt_reg == CNT_W'(1));
    assign st.m_small  = (mod_cfg_reg < WORD_WIDTH'(2));
    assign st.out_busy = m_valid_reg && !m_ready;

    // partial product stays reduced
    a_p_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_MUL && !st.m_small) |=> (p_reg < mod_cfg_reg))
        else $error("partial product not reduced");

    // multiply steps never run past the word
    a_mcnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_MUL) |-> (mcnt_reg != '0))
        else $error("multiply step with exhausted counter");

    // issued result is reduced and valid
    a_out_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_OUT && !st.m_small) |=> (m_valid_reg && m_result_reg < mod_cfg_reg))
        else $error("result not reduced modulo modulus");

endmodule

`default_nettype wire

// ----- design/modular_exponentiation_top.sv -----
// a bit-serial modular multiply loop is shared by every square and multiply, so a new
// item is taken only once the last one is through; a modulus below two skips the loop
// and gives zero; a new item is taken while a result waits in the output register
// reset: synchronous active-low aresetn clears the sequencer and output valid and
// loads exponent 65537 and modulus 4294967291
`default_nettype none

module modular_exponentiation_top import mexp_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [WORD_WIDTH-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [WORD_WIDTH-1:0] s_message,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [WORD_WIDTH-1:0]      m_result
);

    ctrl_t   ctrl;
    status_t st;

    // microprogram sequencer
    mexp_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .ctrl    (ctrl)
    );

    // modular arithmetic datapath
    mexp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .st        (st),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_message (s_message),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

endmodule

`default_nettype wire
